FILE: design/krt_pkg.sv
package krt_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 16;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_LIST   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
  } rec_t;

  // write request into the slot store
  typedef struct packed {
    logic en;
    logic clr;   // free the slot instead of writing it
    rec_t rec;
  } wr_req_t;

  // registered read response from the slot store
  typedef struct packed {
    logic vld;
    logic occ;
    rec_t rec;
  } rd_rsp_t;

  typedef struct packed {
    logic    strobe;
    status_t status;
    rec_t    rec;
    logic    last;
  } res_t;

endpackage

FILE: design/keyed_record_table_unit.sv
// A command whose key is rejected up front gives its result in the cycle after start.
// Other valid commands scan all CAPACITY slots through one read port, one slot per cycle;
// lookup, update, delete and duplicate inserts stop at the first match. Busy stays high
// until the final result of the command comes out.
// List results come out at most one per cycle; the receiver cannot stall them.
// Reset (rst, synchronous) frees every slot at once and returns the sequencer to idle.
module keyed_record_table_unit
  import krt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       command,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] value_first,
  input  logic [VAL_W-1:0] value_second,
  output logic             busy,
  output logic             strobe,
  output logic [2:0]       status,
  output logic [KEY_W-1:0] found_key,
  output logic [VAL_W-1:0] found_first,
  output logic [VAL_W-1:0] found_second,
  output logic             last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          rd_en;
  logic [IW-1:0] rd_idx;
  rd_rsp_t       rsp;
  logic [IW-1:0] rsp_idx;
  wr_req_t       wr;
  logic [IW-1:0] wr_idx;
  res_t          res;

  krt_ctrl #(
    .CAPACITY(CAPACITY),
    .IW      (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .command     (command),
    .key         (key),
    .value_first (value_first),
    .value_second(value_second),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_idx      (rd_idx),
    .rsp         (rsp),
    .rsp_idx     (rsp_idx),
    .wr          (wr),
    .wr_idx      (wr_idx),
    .res         (res)
  );

  krt_store #(
    .CAPACITY(CAPACITY),
    .IW      (IW)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .rsp    (rsp),
    .rsp_idx(rsp_idx),
    .wr     (wr),
    .wr_idx (wr_idx)
  );

  assign strobe       = res.strobe;
  assign status       = res.status;
  assign found_key    = res.rec.key;
  assign found_first  = res.rec.first;
  assign found_second = res.rec.second;
  assign last         = res.last;

endmodule

FILE: design/krt_store.sv
module krt_store
  import krt_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int IW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_idx,
  output rd_rsp_t       rsp,
  output logic [IW-1:0] rsp_idx,
  input  wr_req_t       wr,
  input  logic [IW-1:0] wr_idx
);

  rec_t              mem [CAPACITY];
  logic [CAPACITY-1:0] occ;

  // occupancy bits stand for "key nonzero"; a free slot reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (wr.en) begin
      occ[wr_idx] <= !wr.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && !wr.clr) begin
      mem[wr_idx] <= wr.rec;
    end
  end

  logic occ_q;
  rec_t rec_q;
  logic vld_q;

  always_ff @(posedge clk) begin
    rec_q   <= mem[rd_idx];
    occ_q   <= occ[rd_idx];
    rsp_idx <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= rd_en;
    end
  end

  assign rsp.vld = vld_q;
  assign rsp.occ = occ_q;
  assign rsp.rec = occ_q ? rec_q : '0;

endmodule

FILE: design/krt_ctrl.sv
module krt_ctrl
  import krt_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int IW = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       command,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] value_first,
  input  logic [VAL_W-1:0] value_second,
  output logic             busy,
  output logic             rd_en,
  output logic [IW-1:0]    rd_idx,
  input  rd_rsp_t          rsp,
  input  logic [IW-1:0]    rsp_idx,
  output wr_req_t          wr,
  output logic [IW-1:0]    wr_idx,
  output res_t             res
);

  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  state_t           state, state_next;
  cmd_t             cmd, cmd_next;
  logic [KEY_W-1:0] key_q, key_q_next;
  logic [VAL_W-1:0] va, va_next, vb, vb_next;
  logic [IW-1:0]    idx, idx_next;
  logic             issued_all, issued_all_next;
  logic             free_found, free_found_next;
  logic [IW-1:0]    free_idx, free_idx_next;
  logic             pend, pend_next;
  rec_t             pend_rec, pend_rec_next;
  res_t             res_next;
  logic             hit, last_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issued_all <= 1'b0;
      free_found <= 1'b0;
      pend       <= 1'b0;
      res        <= '0;
    end else begin
      state      <= state_next;
      issued_all <= issued_all_next;
      free_found <= free_found_next;
      pend       <= pend_next;
      res        <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    key_q    <= key_q_next;
    va       <= va_next;
    vb       <= vb_next;
    idx      <= idx_next;
    free_idx <= free_idx_next;
    pend_rec <= pend_rec_next;
  end

  assign busy     = (state != S_IDLE);
  assign rd_idx   = idx;
  assign hit      = rsp.occ && (rsp.rec.key == key_q);
  assign last_rsp = (rsp_idx == LAST_IDX);

  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    key_q_next      = key_q;
    va_next         = va;
    vb_next         = vb;
    idx_next        = idx;
    issued_all_next = issued_all;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    pend_next       = pend;
    pend_rec_next   = pend_rec;
    rd_en           = 1'b0;
    wr              = '0;
    wr_idx          = rsp_idx;
    res_next        = '0;
    res_next.status = ST_OK;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next        = cmd_t'(command);
          key_q_next      = key;
          va_next         = value_first;
          vb_next         = value_second;
          idx_next        = '0;
          issued_all_next = 1'b0;
          free_found_next = 1'b0;
          pend_next       = 1'b0;
          if (command == CMD_INSERT && key == '0) begin
            res_next.strobe = 1'b1;
            res_next.status = ST_INVALID;
            res_next.last   = 1'b1;
          end else if (command inside {CMD_LOOKUP, CMD_UPDATE, CMD_DELETE} && key == '0) begin
            res_next.strobe = 1'b1;
            res_next.status = ST_NOT_FOUND;
            res_next.last   = 1'b1;
          end else if (command inside {CMD_INSERT, CMD_LOOKUP, CMD_UPDATE, CMD_DELETE,
                                       CMD_LIST}) begin
            state_next = S_SCAN;
          end
          // unused codes: dropped without a result
        end
      end

      S_SCAN: begin
        if (!issued_all) begin
          rd_en = 1'b1;
          if (idx == LAST_IDX) begin
            issued_all_next = 1'b1;
          end else begin
            idx_next = idx + IW'(1);
          end
        end

        if (rsp.vld) begin
          case (cmd)
            CMD_INSERT: begin
              if (hit) begin
                res_next.strobe = 1'b1;
                res_next.status = ST_DUPLICATE;
                res_next.last   = 1'b1;
                state_next      = S_IDLE;
              end else begin
                if (!rsp.occ && !free_found) begin
                  free_found_next = 1'b1;
                  free_idx_next   = rsp_idx;
                end
                if (last_rsp) begin
                  res_next.strobe = 1'b1;
                  res_next.last   = 1'b1;
                  if (free_found || !rsp.occ) begin
                    wr.en           = 1'b1;
                    wr.rec          = '{key: key_q, first: va, second: vb};
                    wr_idx          = free_found ? free_idx : rsp_idx;
                    res_next.status = ST_OK;
                    res_next.rec    = '{key: key_q, first: va, second: vb};
                  end else begin
                    res_next.status = ST_FULL;
                  end
                  state_next = S_IDLE;
                end
              end
            end

            CMD_LOOKUP, CMD_UPDATE, CMD_DELETE: begin
              if (hit) begin
                res_next.strobe = 1'b1;
                res_next.status = ST_OK;
                res_next.last   = 1'b1;
                res_next.rec    = rsp.rec;
                if (cmd == CMD_UPDATE) begin
                  wr.en               = 1'b1;
                  wr.rec              = '{key: key_q, first: va, second: vb};
                  res_next.rec.first  = va;
                  res_next.rec.second = vb;
                end else if (cmd == CMD_DELETE) begin
                  wr.en  = 1'b1;
                  wr.clr = 1'b1;
                end
                state_next = S_IDLE;
              end else if (last_rsp) begin
                res_next.strobe = 1'b1;
                res_next.status = ST_NOT_FOUND;
                res_next.last   = 1'b1;
                state_next      = S_IDLE;
              end
            end

            CMD_LIST: begin
              // hold one record back so the final one can carry last
              if (rsp.occ) begin
                if (pend) begin
                  res_next.strobe = 1'b1;
                  res_next.status = ST_OK;
                  res_next.rec    = pend_rec;
                end
                pend_next     = 1'b1;
                pend_rec_next = rsp.rec;
              end
              if (last_rsp) begin
                state_next = S_FLUSH;
              end
            end

            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_FLUSH: begin
        res_next.strobe = 1'b1;
        res_next.last   = 1'b1;
        if (pend) begin
          res_next.status = ST_OK;
          res_next.rec    = pend_rec;
        end else begin
          res_next.status = ST_EMPTY;
        end
        pend_next  = 1'b0;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/krt_checker.sv
module krt_checker
  import krt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             strobe,
  input logic [2:0]       status,
  input logic [KEY_W-1:0] found_key,
  input logic [VAL_W-1:0] found_first,
  input logic [VAL_W-1:0] found_second,
  input logic             last
);

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result strobe right after reset");

  // an error or empty status ends the command and carries no record
  a_fail_is_final: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_OK |-> last && found_key == '0 && found_first == '0
                                  && found_second == '0)
    else $error("non-ok result with record or without last");

  // an ok result always refers to an occupied slot
  a_ok_has_key: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_OK |-> found_key != '0)
    else $error("ok result with key zero");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> status <= ST_EMPTY)
    else $error("status code out of range");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (
  .clk         (clk),
  .rst         (rst),
  .strobe      (strobe),
  .status      (status),
  .found_key   (found_key),
  .found_first (found_first),
  .found_second(found_second),
  .last        (last)
);
